### hdl/swm_pkg.sv
// Shared types and constants for the sliding window maximum block.
// Used by swm_ctrl, swm_dp and sliding_window_maximum.
package swm_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int SAMPLE_W   = 32;
  localparam int CFG_W      = 7;
  localparam int PTR_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W      = PTR_W + 1;
  localparam int POS_W      = PTR_W + 1;
  localparam int ENTRY_W    = POS_W + SAMPLE_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXP_RD,
    ST_EXP_CHK,
    ST_BCK_RD,
    ST_BCK_CHK,
    ST_APPEND,
    ST_FRONT_RD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_front;
    logic rd_back;
    logic drop_head;
    logic drop_tail;
    logic append;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic             count_zero;
    logic             expired;
    logic             smaller;
    logic             window_full;
    logic [CNT_W-1:0] count;
  } dp_status_t;

endpackage

### hdl/swm_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
module swm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/swm_ctrl.sv
// Controller state machine: sequences expiry, back drops, append and result.
// Depends on swm_pkg.
module swm_ctrl
  import swm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_EXP_RD;
      ST_EXP_RD:   state_nxt = status.count_zero ? ST_BCK_RD : ST_EXP_CHK;
      ST_EXP_CHK:  state_nxt = status.expired ? ST_EXP_RD : ST_BCK_RD;
      ST_BCK_RD:   state_nxt = status.count_zero ? ST_APPEND : ST_BCK_CHK;
      ST_BCK_CHK:  state_nxt = status.smaller ? ST_BCK_RD : ST_APPEND;
      ST_APPEND:   state_nxt = status.window_full ? ST_FRONT_RD : ST_IDLE;
      ST_FRONT_RD: state_nxt = ST_OUT;
      ST_OUT:      if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE:     cmd.load = in_valid;
      ST_EXP_RD:   cmd.rd_front = !status.count_zero;
      ST_EXP_CHK:  cmd.drop_head = status.expired;
      ST_BCK_RD:   cmd.rd_back = !status.count_zero;
      ST_BCK_CHK:  cmd.drop_tail = status.smaller;
      ST_APPEND:   cmd.append = 1'b1;
      ST_FRONT_RD: cmd.rd_front = 1'b1;
      ST_OUT:      cmd.out_load = out_free;
      default:     cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

### hdl/swm_dp.sv
// Datapath: circular candidate queue in RAM, counters, window register, result.
// Depends on swm_pkg and swm_ram.
module swm_dp
  import swm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [CFG_W-1:0]    cfg_wr_data,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                in_start_req,
  input  dp_cmd_t             cmd,
  output dp_status_t          status,
  output logic [SAMPLE_W-1:0] window_max
);

  logic [CFG_W-1:0]    window_size_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [PTR_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [CNT_W-1:0]    seen_r, seen_nxt;
  logic [SAMPLE_W-1:0] max_r;

  logic [CNT_W-1:0]    k_eff;
  logic [CNT_W-1:0]    seen_upd;
  logic [POS_W-1:0]    age;
  logic                full;
  logic                rd_en;
  logic [PTR_W-1:0]    rd_addr;
  logic [PTR_W-1:0]    wr_addr;
  logic [ENTRY_W-1:0]  rd_data;
  logic [SAMPLE_W-1:0] rd_value;
  logic [POS_W-1:0]    rd_pos;

  swm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_WINDOW)
  ) u_queue (
    .clk     (clk),
    .wr_en   (cmd.append),
    .wr_addr (wr_addr),
    .wr_data ({pos_r, sample_r}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    if (window_size_r == '0) begin
      k_eff = CNT_W'(1);
    end else if (window_size_r > CFG_W'(MAX_WINDOW)) begin
      k_eff = CNT_W'(MAX_WINDOW);
    end else begin
      k_eff = CNT_W'(window_size_r);
    end
  end

  assign rd_value = rd_data[SAMPLE_W-1:0];
  assign rd_pos   = rd_data[ENTRY_W-1:SAMPLE_W];
  assign age      = pos_r - rd_pos;
  assign full     = (count_r == CNT_W'(MAX_WINDOW));
  assign rd_en    = cmd.rd_front || cmd.rd_back;
  assign rd_addr  = cmd.rd_back ? (head_r + count_r[PTR_W-1:0] - PTR_W'(1)) : head_r;
  assign wr_addr  = head_r + count_r[PTR_W-1:0];
  assign seen_upd = (seen_r < k_eff) ? (seen_r + CNT_W'(1)) : k_eff;

  assign status.count_zero  = (count_r == '0);
  assign status.expired     = (CNT_W'(age) >= k_eff);
  assign status.smaller     = ($signed(rd_value) < $signed(sample_r));
  assign status.window_full = (seen_upd >= k_eff);
  assign status.count       = count_r;

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    seen_nxt  = seen_r;
    if (cmd.load && in_start_req) begin
      count_nxt = '0;
      pos_nxt   = '0;
      seen_nxt  = '0;
    end
    if (cmd.drop_head) begin
      head_nxt  = head_r + PTR_W'(1);
      count_nxt = count_r - CNT_W'(1);
    end
    if (cmd.drop_tail) begin
      count_nxt = count_r - CNT_W'(1);
    end
    if (cmd.append) begin
      // drop the oldest entry when the queue is full
      if (full) begin
        head_nxt = head_r + PTR_W'(1);
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
      pos_nxt  = pos_r + POS_W'(1);
      seen_nxt = seen_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= CFG_W'(1);
      head_r        <= '0;
      count_r       <= '0;
      pos_r         <= '0;
      seen_r        <= '0;
    end else begin
      if (cfg_wr_en) begin
        window_size_r <= cfg_wr_data;
      end
      head_r  <= head_nxt;
      count_r <= count_nxt;
      pos_r   <= pos_nxt;
      seen_r  <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_sample;
    end
    if (cmd.out_load) begin
      max_r <= rd_value;
    end
  end

  assign window_max = max_r;

endmodule

### hdl/sliding_window_maximum.sv
// Top level of the sliding window maximum block: controller plus datapath.
// Depends on swm_pkg, swm_ctrl, swm_dp and swm_ram.
//
//   Channel  Handshake            Payload
//   in       in_valid/in_stall    in_sample, in_start_req
//   out      out_valid/out_stall  out_window_max
//   cfg      cfg_wr_en            cfg_wr_data (window_size)
//
// One sample at a time: the sample is accepted, then the expiry scan at the
// front and the scan for smaller values at the back each read and then check
// one entry per step until a check stops them or the queue is empty, then the
// sample is appended; a result adds a front read and an output load, plus any
// wait on out_stall. All queue reads use the single registered read port of the RAM.
// Synchronous active-low reset clears the queue, counters and window size (1).
// A finished result waits in the output register; the next sample is taken
// meanwhile, and its result is held back until out_stall drops.
module sliding_window_maximum
  import swm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [CFG_W-1:0]    cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                in_start_req,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SAMPLE_W-1:0] out_window_max
);

  dp_cmd_t    cmd;
  dp_status_t status;

  swm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  swm_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_sample    (in_sample),
    .in_start_req (in_start_req),
    .cmd          (cmd),
    .status       (status),
    .window_max   (out_window_max)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    status.count <= CNT_W'(MAX_WINDOW))
    else $error("queue count above capacity");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second sample taken while one is in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("pending result overwritten");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.drop_head || cmd.drop_tail) |-> !status.count_zero)
    else $error("pop from empty queue");

endmodule
